// File: hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache core.
// Used by the controller, the datapath and the top level; depends on nothing.
package lkv_pkg;

   // request kinds carried in req_tuser
   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   // read value returned on a get miss and on every put
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   // width of the capacity register
   localparam int CAP_WIDTH = 5;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request fields
      logic lookup;    // compare the key against every entry
      logic resolve;   // locate hit, victim and read the stored value
      logic commit;    // update ranks, write back, load the result register
   } lkv_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;  // result register can take a new result this cycle
   } lkv_status_type;

endpackage

// File: hw/rtl/lkv_ctrl.sv
// Sequencing state machine for the LRU key/value cache core.
// Depends on lkv_pkg for the command and status structs.
module lkv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output lkv_pkg::lkv_cmd_type    cmd,
   input  lkv_pkg::lkv_status_type status
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_LOOKUP  = 2'd1;
   localparam logic [1:0] ST_RESOLVE = 2'd2;
   localparam logic [1:0] ST_UPDATE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // take a new request only between items
   assign req_tready = (state_ff == ST_IDLE);

   // issue one command per state; hold the update until the result slot frees
   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/lkv_dpath.sv
// Entry storage, key compare, rank bookkeeping and result register.
// Depends on lkv_pkg for commands, status and constants.
module lkv_dpath #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lkv_pkg::lkv_cmd_type               cmd,
   output lkv_pkg::lkv_status_type            status,
   input  logic [lkv_pkg::CAP_WIDTH-1:0]      capacity,
   input  logic                               req_action,
   input  logic [31:0]                        req_key,
   input  logic [31:0]                        req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [31:0]                        rsp_read_value
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = (OW > lkv_pkg::CAP_WIDTH) ? OW : lkv_pkg::CAP_WIDTH;

   // captured request
   logic                    put_ff;
   logic [31:0]             key_ff;
   logic [31:0]             val_ff;

   // entry state
   logic [31:0]             entry_key_ff [MAX_ENTRIES];
   logic [31:0]             value_mem    [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]  valid_ff;
   logic [MAX_ENTRIES-1:0]  valid_in;
   logic [IW-1:0]           rank_ff [MAX_ENTRIES];
   logic [IW-1:0]           rank_in [MAX_ENTRIES];
   logic [OW-1:0]           occ_ff;
   logic [OW-1:0]           occ_in;

   // per-item intermediate results
   logic [MAX_ENTRIES-1:0]  match_ff;
   logic                    hit_ff;
   logic                    hit_in;
   logic [IW-1:0]           hit_idx_ff;
   logic [IW-1:0]           hit_idx_in;
   logic [IW-1:0]           hit_rank_ff;
   logic [IW-1:0]           hit_rank_in;
   logic [MAX_ENTRIES-1:0]  evict_ff;
   logic [MAX_ENTRIES-1:0]  evict_in;
   logic [31:0]             rd_ff;

   // update-stage signals
   logic [MAX_ENTRIES-1:0]  free_vec;
   logic [IW-1:0]           free_idx;
   logic                    have_free;
   logic                    do_insert;
   logic                    evict_any;

   // effective capacity and eviction test
   logic [CW-1:0]           cap_ext;
   logic [CW-1:0]           cap_eff;
   logic                    need_evict;

   // result register
   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;
   logic [31:0]             rsp_data_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_data_ff;

   // latch the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         put_ff <= (req_action == lkv_pkg::ACTION_PUT);
         key_ff <= req_key;
         val_ff <= req_value;
      end
   end

   // compare the key against every valid entry
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_ff[i] <= valid_ff[i] && (entry_key_ff[i] == key_ff);
         end
      end
   end

   // clamp capacity to 1..MAX_ENTRIES
   always_comb begin
      cap_ext = CW'(capacity);
      if (cap_ext == '0) begin
         cap_eff = CW'(1);
      end else if (cap_ext > CW'(MAX_ENTRIES)) begin
         cap_eff = CW'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
      need_evict = put_ff && !hit_in && (CW'(occ_ff) >= cap_eff);
   end

   // encode the hit (keys are unique, so the match is one-hot) and mark the victim
   always_comb begin
      hit_in      = |match_ff;
      hit_idx_in  = '0;
      hit_rank_in = '0;
      evict_in    = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (match_ff[i]) begin
            hit_idx_in  = hit_idx_in | IW'(i);
            hit_rank_in = hit_rank_in | rank_ff[i];
         end
         evict_in[i] = need_evict && valid_ff[i] && (rank_ff[i] == IW'(occ_ff - OW'(1)));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_idx_in;
         hit_rank_ff <= hit_rank_in;
         evict_ff    <= evict_in;
      end
   end

   // pick the lowest free slot once the victim is dropped
   always_comb begin
      free_vec = ~valid_ff | evict_ff;
      have_free = |free_vec;
      free_idx  = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_idx = IW'(i);
         end
      end
      do_insert = put_ff && !hit_ff && have_free;
      evict_any = |evict_ff;
   end

   // next valid marks, ranks and occupancy
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (hit_ff) begin
            if (match_ff[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
               rank_in[i] = rank_ff[i] + IW'(1);
            end
         end else if (put_ff) begin
            if (evict_ff[i]) begin
               valid_in[i] = 1'b0;
               rank_in[i]  = '0;
            end
            if (do_insert && (free_idx == IW'(i))) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (do_insert && valid_in[i]) begin
               rank_in[i] = rank_ff[i] + IW'(1);
            end
         end
      end
      occ_in = occ_ff - OW'(evict_any) + OW'(do_insert);
   end

   // commit entry state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // write the key of a new entry
   always_ff @(posedge clock) begin
      if (cmd.commit && do_insert) begin
         entry_key_ff[free_idx] <= key_ff;
      end
   end

   // value memory: read at the hit slot, write on put hit or insert
   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         rd_ff <= value_mem[hit_idx_in];
      end
      if (cmd.commit && put_ff && hit_ff) begin
         value_mem[hit_idx_ff] <= val_ff;
      end else if (cmd.commit && do_insert) begin
         value_mem[free_idx] <= val_ff;
      end
   end

   // result register: load on commit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff  <= hit_ff;
         rsp_data_ff <= (hit_ff && !put_ff) ? rd_ff : lkv_pkg::MISS_VALUE;
      end
   end

endmodule

// File: hw/rtl/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement. Each request
// is a get or a put and yields exactly one response: hit, plus the stored value on a
// get hit or all ones otherwise. The response is loaded in steps after the request
// transfer (the transfer edge captures the request, then parallel key compare, hit/victim
// resolve with the value memory read, rank update and write-back); the next request is
// taken the cycle after the response is loaded, so one request is in flight at a time;
// the update waits while an earlier response waits in the output register. The single
// value memory port and the compare/resolve/update sequence set that limit.
// capacity_in_use (byte address 0) limits how many entries are held; 0 acts as 1 and
// values above MAX_ENTRIES act as MAX_ENTRIES. Valid marks and ranks clear at reset at
// once; no clearing pass is needed. Write the capacity only while no request is in flight.
module lru_key_value_cache_core #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] key, [63:32] value
   input  logic [0:0]  req_tuser,   // [0] action (0 get, 1 put)
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_value
   output logic [0:0]  rsp_tuser,   // [0] hit
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_CAPACITY = 1'b0;

   lkv_pkg::lkv_cmd_type             cmd;
   lkv_pkg::lkv_status_type          status;
   logic [lkv_pkg::CAP_WIDTH-1:0]    cap_ff;
   logic                             csr_write;

   // register port: capacity at word 0, other words ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_pkg::CAP_WIDTH'(16);
      end else if (csr_write && (csr_paddr[2] == REG_CAPACITY)) begin
         cap_ff <= csr_pwdata[lkv_pkg::CAP_WIDTH-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ?
                       {{(32 - lkv_pkg::CAP_WIDTH){1'b0}}, cap_ff} : 32'd0;

   lkv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   lkv_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .capacity       (cap_ff),
      .req_action     (req_tuser[0]),
      .req_key        (req_tdata[31:0]),
      .req_value      (req_tdata[63:32]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_hit        (rsp_tuser[0]),
      .rsp_read_value (rsp_tdata)
   );

endmodule

// File: hw/rtl/lkv_check.sv
// Port-level checks for the LRU key/value cache core, bound to the top level.
// Depends only on the top-level ports.
module lkv_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // a miss always reads back all ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'hFFFF_FFFF)
      else $error("miss response carries data");

   // one request in flight: req_tready stays low through the lookup, resolve and update steps after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("request taken while busy");

   // a fresh response only follows request work
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without request");

   // capacity write reads back
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]
      ##1 !csr_paddr[2] |-> csr_prdata[4:0] == $past(csr_pwdata[4:0]))
      else $error("capacity readback mismatch");

endmodule

bind lru_key_value_cache_core lkv_check u_lkv_check (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);
